// ===== rtl/rkf_pkg.sv =====
package rkf_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int CHAN_BITS     = 8;
    localparam int PIX_BITS      = 3 * CHAN_BITS;
    localparam int KIND_BITS     = 2;
    localparam int WIDTH_BITS    = 11;
    localparam int HEIGHT_BITS   = 13;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int ADDR_BITS     = 5;
    localparam int DATA_BITS     = 32;
    localparam int SUM4_BITS     = 10;
    localparam int SUM_BITS      = 12;
    localparam int ACC_BITS      = 13;

    // floor(s / 9) == (s * RECIP9) >> RECIP9_SHIFT for every s up to 9 * 255
    localparam int RECIP9        = 7282;
    localparam int RECIP9_SHIFT  = 16;
    localparam int RECIP9_BITS   = 13;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RST  = WIDTH_BITS'(1024);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST = HEIGHT_BITS'(1);

    typedef logic [PIX_BITS-1:0] rgb_t;

    typedef enum logic [KIND_BITS-1:0] {
        FILT_EDGE    = 2'd0,
        FILT_SHARPEN = 2'd1,
        FILT_BOX     = 2'd2,
        FILT_GAUSS   = 2'd3
    } filter_kind_t;

    typedef enum logic [2:0] {
        REG_FILTER_KIND  = 3'd0,
        REG_IMAGE_WIDTH  = 3'd1,
        REG_IMAGE_HEIGHT = 3'd2,
        REG_SEL_X_START  = 3'd3,
        REG_SEL_Y_START  = 3'd4,
        REG_SEL_X_END    = 3'd5,
        REG_SEL_Y_END    = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0] red_in;
        logic [CHAN_BITS-1:0] green_in;
        logic [CHAN_BITS-1:0] blue_in;
        logic                 is_padding;
    } pix_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0] red_out;
        logic [CHAN_BITS-1:0] green_out;
        logic [CHAN_BITS-1:0] blue_out;
        logic                 frame_last;
    } res_t;

    // line store requests issued by the pixel pipeline
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ls_req_t;

    // one channel of the 3x3 kernel from its corner sum, side sum and center
    function automatic logic [CHAN_BITS-1:0] kernel_chan(
        filter_kind_t          kind,
        logic [SUM4_BITS-1:0]  corners,
        logic [SUM4_BITS-1:0]  sides,
        logic [CHAN_BITS-1:0]  center
    );
        logic signed [ACC_BITS-1:0]          acc;
        logic [SUM_BITS-1:0]                 total;
        logic [SUM_BITS+RECIP9_BITS-1:0]     prod;
        logic [CHAN_BITS-1:0]                result;
        acc    = '0;
        total  = '0;
        prod   = '0;
        result = '0;
        case (kind)
            FILT_EDGE:
            begin
                acc = $signed({2'b00, center, 3'b000})
                      - $signed({3'b000, corners}) - $signed({3'b000, sides});
            end
            FILT_SHARPEN:
            begin
                acc = $signed({3'b000, center, 2'b00}) + $signed({5'b00000, center})
                      - $signed({3'b000, sides});
            end
            FILT_BOX:
            begin
                total  = SUM_BITS'(corners) + SUM_BITS'(sides) + SUM_BITS'(center);
                prod   = (SUM_BITS+RECIP9_BITS)'(total)
                         * (SUM_BITS+RECIP9_BITS)'(RECIP9);
                result = prod[RECIP9_SHIFT +: CHAN_BITS];
            end
            default:
            begin
                total  = SUM_BITS'(corners) + {1'b0, sides, 1'b0}
                         + {2'b00, center, 2'b00};
                result = total[SUM_BITS-1:4];
            end
        endcase
        if (kind == FILT_EDGE || kind == FILT_SHARPEN)
        begin
            if (acc < 0)
                result = '0;
            else if (acc > $signed(ACC_BITS'(255)))
                result = '1;
            else
                result = acc[CHAN_BITS-1:0];
        end
        return result;
    endfunction

endpackage

// ===== rtl/rgb_3x3_kernel_filter.sv =====
// 3x3 kernel filter on an RGB raster stream.
//
// Pixel channel (pix_valid / pix_ready / pix): pixels in raster order, then
// image_width+1 padding transfers (is_padding set) that flush the last line.
// Result channel (res_valid / res_ready / res): one transfer per image pixel,
// in raster order, frame_last set on the final one. A pixel's result is
// caused by the transfer one line plus one pixel after it.
// Configuration: APB-style port, register i at byte address 4*i, pready tied
// high. Write registers only while the stream is idle.
//
// Throughput: one pixel per clock unless the result channel stalls. Each pixel
// needs one read of both line stores and one write back; the line store reads
// at the accept stage and writes from stage 1, with same-entry forwarding, so
// the pipeline never interlocks. A result passes the stage 1, stage 2 and result registers.
// Reset: both line stores are zeroed by a clearing pass over all MAX_WIDTH entries;
// pix_ready stays low during it, configuration writes are taken throughout.
// Stall: when res_ready is low with a result waiting, the whole pipeline
// holds and pix_ready drops in the same cycle.
module rgb_3x3_kernel_filter #(
    parameter int MAX_WIDTH = rkf_pkg::MAX_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rkf_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [rkf_pkg::DATA_BITS-1:0]  pwdata,
    output logic [rkf_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    input  logic                           pix_valid,
    output logic                           pix_ready,
    input  rkf_pkg::pix_t                  pix,
    output logic                           res_valid,
    input  logic                           res_ready,
    output rkf_pkg::res_t                  res
);
    import rkf_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int KW = (CW > WIDTH_BITS) ? CW : WIDTH_BITS;
    localparam int HW = HEIGHT_BITS;

    // ---------------- configuration registers ----------------
    filter_kind_t           filter_kind_reg;
    logic [WIDTH_BITS-1:0]  image_width_reg;
    logic [HW-1:0]          image_height_reg;
    logic [WIDTH_BITS-1:0]  sel_x_start_reg;
    logic [HW-1:0]          sel_y_start_reg;
    logic [WIDTH_BITS-1:0]  sel_x_end_reg;
    logic [HW-1:0]          sel_y_end_reg;

    logic                   cfg_write;
    reg_idx_t               cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_BITS-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_kind_reg  <= FILT_EDGE;
            image_width_reg  <= WIDTH_RST;
            image_height_reg <= HEIGHT_RST;
            sel_x_start_reg  <= '0;
            sel_y_start_reg  <= '0;
            sel_x_end_reg    <= WIDTH_RST;
            sel_y_end_reg    <= HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_FILTER_KIND:  filter_kind_reg  <= filter_kind_t'(pwdata[KIND_BITS-1:0]);
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[HW-1:0];
                REG_SEL_X_START:  sel_x_start_reg  <= pwdata[WIDTH_BITS-1:0];
                REG_SEL_Y_START:  sel_y_start_reg  <= pwdata[HW-1:0];
                REG_SEL_X_END:    sel_x_end_reg    <= pwdata[WIDTH_BITS-1:0];
                REG_SEL_Y_END:    sel_y_end_reg    <= pwdata[HW-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_FILTER_KIND:  prdata = DATA_BITS'(filter_kind_reg);
            REG_IMAGE_WIDTH:  prdata = DATA_BITS'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = DATA_BITS'(image_height_reg);
            REG_SEL_X_START:  prdata = DATA_BITS'(sel_x_start_reg);
            REG_SEL_Y_START:  prdata = DATA_BITS'(sel_y_start_reg);
            REG_SEL_X_END:    prdata = DATA_BITS'(sel_x_end_reg);
            REG_SEL_Y_END:    prdata = DATA_BITS'(sel_y_end_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- effective frame size ----------------
    // Zero width or height acts as one; oversize values clamp to the limits.
    logic [KW-1:0] width_k;
    logic [KW-1:0] w_eff;
    logic [KW-1:0] w_last_k;
    logic [XW-1:0] w_last;
    logic [HW-1:0] h_eff;
    logic [HW-1:0] h_minus1;
    logic [HW-1:0] h_plus1;
    logic [HW-1:0] h_plus2;

    always_comb
    begin
        width_k = KW'(image_width_reg);
        if (width_k == '0)
            w_eff = KW'(1);
        else if (width_k > KW'(MAX_WIDTH))
            w_eff = KW'(MAX_WIDTH);
        else
            w_eff = width_k;
        w_last_k = w_eff - KW'(1);
        w_last   = w_last_k[XW-1:0];

        if (image_height_reg == '0)
            h_eff = HW'(1);
        else if (image_height_reg > HW'(HEIGHT_LIMIT))
            h_eff = HW'(HEIGHT_LIMIT);
        else
            h_eff = image_height_reg;
        h_minus1 = h_eff - HW'(1);
        h_plus1  = h_eff + HW'(1);
        h_plus2  = h_eff + HW'(2);
    end

    // ---------------- pipeline control ----------------
    logic    adv;
    logic    accept;
    logic    clearing;
    logic    out_valid_reg;
    ls_req_t ls_req;

    // every stage moves together whenever the output register can take data
    assign adv       = !out_valid_reg || res_ready;
    assign pix_ready = adv && !clearing;
    assign accept    = pix_valid && pix_ready;

    // ---------------- accept stage: raster position ----------------
    logic [XW-1:0] col_reg;
    logic [XW-1:0] col_next;
    logic [HW-1:0] row_reg;
    logic [HW-1:0] row_next;
    rgb_t          sample;

    assign sample = pix.is_padding ? '0 : {pix.red_in, pix.green_in, pix.blue_in};

    // advance over the extended raster; wrap after row image_height+1
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_reg >= h_plus1)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (KW'(col_reg) >= w_last_k)
            begin
                col_next = '0;
                row_next = row_reg + HW'(1);
            end
            else
            begin
                col_next = col_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- stage 1: line data back, window shift ----------------
    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic [XW-1:0] s1_x_reg;
    logic [HW-1:0] s1_y_reg;
    rgb_t          s1_sample_reg;

    assign s1_valid_next = adv ? accept : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg      <= col_reg;
            s1_y_reg      <= row_reg;
            s1_sample_reg <= sample;
        end
    end

    rgb_t older_q;
    rgb_t newer_q;
    rgb_t wrap_q;

    assign ls_req.rd_en = accept;
    assign ls_req.wr_en = s1_valid_reg && adv;

    // the older line takes the newer line's entry, the newer line the new pixel
    rkf_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (ls_req),
        .rd_addr   (col_reg),
        .wrap_addr (w_last),
        .wr_addr   (s1_x_reg),
        .wr_older  (newer_q),
        .wr_newer  (s1_sample_reg),
        .older_q   (older_q),
        .newer_q   (newer_q),
        .wrap_q    (wrap_q),
        .clearing  (clearing)
    );

    // 3x3 window, row-major, index 4 the center; shift left, load right column
    logic [8:0][PIX_BITS-1:0] window_reg;
    logic [8:0][PIX_BITS-1:0] window_next;
    logic [8:0][PIX_BITS-1:0] win_shift;

    always_comb
    begin
        win_shift[0] = window_reg[1];
        win_shift[1] = window_reg[2];
        win_shift[2] = older_q;
        win_shift[3] = window_reg[4];
        win_shift[4] = window_reg[5];
        win_shift[5] = newer_q;
        win_shift[6] = window_reg[7];
        win_shift[7] = window_reg[8];
        win_shift[8] = s1_sample_reg;
        window_next  = ls_req.wr_en ? win_shift : window_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= '0;
        else
            window_reg <= window_next;
    end

    // where the result of this item sits in the image, and whether it exists
    logic            s1_first_col;
    logic            s1_has_res;
    logic            s1_pass;
    logic            s1_last;
    rgb_t            s1_pass_pix;
    logic [HW-1:0]   oy;
    logic [XW-1:0]   ox;
    logic            border;
    logic            selected;

    always_comb
    begin
        s1_first_col = (s1_x_reg == '0);
        oy           = s1_y_reg - HW'(1);
        ox           = s1_x_reg - XW'(1);
        border       = (oy == '0) || (ox == '0) || (oy == h_minus1) || (ox == w_last);
        selected     = (KW'(ox) >= KW'(sel_x_start_reg)) && (KW'(ox) < KW'(sel_x_end_reg))
                       && (oy >= sel_y_start_reg) && (oy < sel_y_end_reg);
        if (s1_first_col)
        begin
            // first column emits the last pixel of the row two lines back
            s1_has_res  = (s1_y_reg >= HW'(2)) && (s1_y_reg < h_plus2);
            s1_last     = (s1_y_reg == h_plus1);
            s1_pass     = 1'b1;
            s1_pass_pix = wrap_q;
        end
        else
        begin
            s1_has_res  = (s1_y_reg >= HW'(1)) && (s1_y_reg < h_plus1);
            s1_last     = (oy == h_minus1) && (ox == w_last);
            s1_pass     = border || !selected;
            s1_pass_pix = win_shift[4];
        end
    end

    // per-channel corner and side sums of the shifted window
    logic [2:0][SUM4_BITS-1:0] s1_corners;
    logic [2:0][SUM4_BITS-1:0] s1_sides;
    logic [2:0][CHAN_BITS-1:0] s1_center;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            s1_corners[ch] = SUM4_BITS'(win_shift[0][PIX_BITS-1-CHAN_BITS*ch -: CHAN_BITS])
                           + SUM4_BITS'(win_shift[2][PIX_BITS-1-CHAN_BITS*ch -: CHAN_BITS])
                           + SUM4_BITS'(win_shift[6][PIX_BITS-1-CHAN_BITS*ch -: CHAN_BITS])
                           + SUM4_BITS'(win_shift[8][PIX_BITS-1-CHAN_BITS*ch -: CHAN_BITS]);
            s1_sides[ch]   = SUM4_BITS'(win_shift[1][PIX_BITS-1-CHAN_BITS*ch -: CHAN_BITS])
                           + SUM4_BITS'(win_shift[3][PIX_BITS-1-CHAN_BITS*ch -: CHAN_BITS])
                           + SUM4_BITS'(win_shift[5][PIX_BITS-1-CHAN_BITS*ch -: CHAN_BITS])
                           + SUM4_BITS'(win_shift[7][PIX_BITS-1-CHAN_BITS*ch -: CHAN_BITS]);
            s1_center[ch]  = win_shift[4][PIX_BITS-1-CHAN_BITS*ch -: CHAN_BITS];
        end
    end

    // ---------------- stage 2: registered sums ----------------
    logic                      s2_valid_reg;
    logic                      s2_valid_next;
    logic                      s2_pass_reg;
    logic                      s2_last_reg;
    rgb_t                      s2_pass_pix_reg;
    logic [2:0][SUM4_BITS-1:0] s2_corners_reg;
    logic [2:0][SUM4_BITS-1:0] s2_sides_reg;
    logic [2:0][CHAN_BITS-1:0] s2_center_reg;

    assign s2_valid_next = adv ? (s1_valid_reg && s1_has_res) : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s2_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_pass_reg     <= s1_pass;
            s2_last_reg     <= s1_last;
            s2_pass_pix_reg <= s1_pass_pix;
            s2_corners_reg  <= s1_corners;
            s2_sides_reg    <= s1_sides;
            s2_center_reg   <= s1_center;
        end
    end

    // ---------------- output stage: kernel and result register ----------------
    logic [2:0][CHAN_BITS-1:0] filt;
    rgb_t                      out_pix;
    logic                      out_valid_next;
    res_t                      res_reg;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
            filt[ch] = kernel_chan(filter_kind_reg, s2_corners_reg[ch],
                                   s2_sides_reg[ch], s2_center_reg[ch]);
        out_pix = s2_pass_reg ? s2_pass_pix_reg : {filt[0], filt[1], filt[2]};
    end

    assign out_valid_next = adv ? s2_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // load only on a real result; hold while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg)
        begin
            res_reg.red_out    <= out_pix[PIX_BITS-1 -: CHAN_BITS];
            res_reg.green_out  <= out_pix[PIX_BITS-1-CHAN_BITS -: CHAN_BITS];
            res_reg.blue_out   <= out_pix[CHAN_BITS-1:0];
            res_reg.frame_last <= s2_last_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    a_accept_enters_stage1: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg
    ) else $error("accepted pixel did not reach the line store stage");

    a_stall_holds_pipeline: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> $stable(window_reg) && $stable(s2_valid_reg)
                                      && $stable(s1_valid_reg)
    ) else $error("pipeline moved while the result was stalled");

    a_no_work_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing |-> !s1_valid_reg && !s2_valid_reg && !pix_ready
    ) else $error("pixel in flight during line store clearing");

endmodule

// ===== rtl/rkf_line_store.sv =====
module rkf_line_store #(
    parameter int MAX_WIDTH = rkf_pkg::MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rkf_pkg::ls_req_t              req,
    input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0]  wrap_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
    input  rkf_pkg::rgb_t                 wr_older,
    input  rkf_pkg::rgb_t                 wr_newer,
    output rkf_pkg::rgb_t                 older_q,
    output rkf_pkg::rgb_t                 newer_q,
    output rkf_pkg::rgb_t                 wrap_q,
    output logic                          clearing
);
    import rkf_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);

    rgb_t older_mem [MAX_WIDTH];
    rgb_t newer_mem [MAX_WIDTH];

    logic          clear_reg;
    logic          clear_next;
    logic [XW-1:0] clear_addr_reg;
    logic [XW-1:0] clear_addr_next;

    rgb_t          older_raw_reg;
    rgb_t          newer_raw_reg;
    rgb_t          wrap_raw_reg;
    rgb_t          fwd_older_reg;
    rgb_t          fwd_newer_reg;
    logic          hit_x_reg;
    logic          hit_x_next;
    logic          hit_w_reg;
    logic          hit_w_next;

    // sweep zeros through both lines after reset
    always_comb
    begin
        clear_next      = clear_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_reg)
        begin
            clear_addr_next = clear_addr_reg + XW'(1);
            if (clear_addr_reg == XW'(MAX_WIDTH - 1))
                clear_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
        end
        else
        begin
            clear_reg      <= clear_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_reg)
        begin
            older_mem[clear_addr_reg] <= '0;
            newer_mem[clear_addr_reg] <= '0;
        end
        else if (req.wr_en)
        begin
            older_mem[wr_addr] <= wr_older;
            newer_mem[wr_addr] <= wr_newer;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            older_raw_reg <= older_mem[rd_addr];
            newer_raw_reg <= newer_mem[rd_addr];
            wrap_raw_reg  <= older_mem[wrap_addr];
            fwd_older_reg <= wr_older;
            fwd_newer_reg <= wr_newer;
        end
    end

    // a write landing on the same edge as the read is forwarded
    always_comb
    begin
        hit_x_next = hit_x_reg;
        hit_w_next = hit_w_reg;
        if (req.rd_en)
        begin
            hit_x_next = req.wr_en && (wr_addr == rd_addr);
            hit_w_next = req.wr_en && (wr_addr == wrap_addr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_x_reg <= 1'b0;
            hit_w_reg <= 1'b0;
        end
        else
        begin
            hit_x_reg <= hit_x_next;
            hit_w_reg <= hit_w_next;
        end
    end

    assign older_q  = hit_x_reg ? fwd_older_reg : older_raw_reg;
    assign newer_q  = hit_x_reg ? fwd_newer_reg : newer_raw_reg;
    assign wrap_q   = hit_w_reg ? fwd_older_reg : wrap_raw_reg;
    assign clearing = clear_reg;

    a_no_read_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clear_reg |-> !req.rd_en && !req.wr_en
    ) else $error("line store accessed during clearing pass");

    a_clear_covers_all: assert property (
        @(posedge clk) disable iff (!rst_n)
        $fell(clear_reg) |-> $past(clear_addr_reg) == XW'(MAX_WIDTH - 1)
    ) else $error("clearing pass ended early");

    a_forward_same_entry: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req.rd_en && req.wr_en && rd_addr == wr_addr)
            |=> (older_q == $past(wr_older)) && (newer_q == $past(wr_newer))
    ) else $error("same-entry write not forwarded to read");

endmodule
